[rtl/core/assert_macros.svh]
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is high.
`define ASSERT_RST(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that is checked in every cycle, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/core/lsbl_pkg.sv]
`default_nettype none

package lsbl_pkg;

   // Data memory depth; a power of two, word_address is taken modulo it.
   localparam int MEM_WORDS = 1024;
   localparam int ADDR_W    = $clog2(MEM_WORDS);

   typedef logic [ADDR_W-1:0] mem_addr_type;

   localparam logic [5:0] OP_LB  = 6'h20;
   localparam logic [5:0] OP_LW  = 6'h23;
   localparam logic [5:0] OP_LBU = 6'h24;
   localparam logic [5:0] OP_LHU = 6'h25;
   localparam logic [5:0] OP_SB  = 6'h28;
   localparam logic [5:0] OP_SH  = 6'h29;
   localparam logic [5:0] OP_SW  = 6'h2b;
   localparam logic [5:0] OP_JAL = 6'h03;

   localparam logic [1:0] KIND_R = 2'd0;
   localparam logic [1:0] KIND_I = 2'd1;

   localparam logic [1:0] LANE_TOP = 2'd3;

   localparam logic [31:0] BYTE_MASK = 32'h0000_00ff;
   localparam logic [31:0] HALF_MASK = 32'h0000_ffff;
   localparam logic [31:0] BYTE_SEXT = 32'hffff_ff00;

   typedef struct packed {
      logic [5:0]  action;
      logic [1:0]  instr_kind;
      logic        bubble;
      logic [9:0]  word_address;
      logic [1:0]  byte_index;
      logic [31:0] store_data;
      logic [31:0] passed_value;
      logic [4:0]  target_reg;
      logic [4:0]  result_reg;
   } req_type;

   typedef struct packed {
      logic [31:0] write_value;
      logic [4:0]  write_reg;
      logic        skip_writeback;
      logic [1:0]  kind_out;
      logic [5:0]  opcode_out;
      logic        lane_error;
   } rsp_type;

   // Write-back of a store into the addressed word.
   typedef struct packed {
      logic        en;
      logic [31:0] data;
   } mem_wr_type;

   function automatic mem_addr_type mem_index(input logic [9:0] word_address);
      return ADDR_W'(word_address);
   endfunction

endpackage

`default_nettype wire

[rtl/core/load_store_byte_lane_stage.sv]
// Path: the memory is read and stage A is loaded at the accepting edge; the result register
//   loads when stage A advances, which a stall on rsp_ready can hold back.
// Throughput: one request per cycle while rsp_ready holds, set by the single read and write port
//   of the data memory; a one-entry bypass covers a store followed by an access to the same word.
// Reset: synchronous, active high; afterwards a clearing pass zeroes all MEM_WORDS words,
//   one per cycle, with req_ready held low until it finishes.
`default_nettype none

module load_store_byte_lane_stage import lsbl_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output      logic    req_ready,
   input  wire req_type req_payload,
   output      logic    rsp_valid,
   input  wire logic    rsp_ready,
   output      rsp_type rsp_payload
);

`include "assert_macros.svh"

   // Clearing pass state
   logic         clear_busy_ff, clear_busy_in;
   mem_addr_type clr_addr_ff, clr_addr_in;

   // Stage A: request whose memory word is being read
   logic         a_valid_ff, a_valid_in;
   req_type      a_req_ff, a_req_in;

   // Bypass: write that landed at the same edge as stage A's read
   logic         fwd_hit_ff, fwd_hit_in;
   logic [31:0]  fwd_data_ff, fwd_data_in;

   // Output register
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_type      rsp_ff, rsp_in;

   logic         accept;
   logic         advance;
   mem_addr_type req_index;
   mem_addr_type a_index;
   logic [31:0]  ram_rd_data;
   logic [31:0]  mem_word;
   logic         wr_en;
   mem_addr_type wr_addr;
   logic [31:0]  wr_data;
   rsp_type      lane_rsp;
   mem_wr_type   lane_wr;

   assign req_index = mem_index(req_payload.word_address);
   assign a_index   = mem_index(a_req_ff.word_address);

   // Stage A moves on whenever the output register is free or being drained.
   assign advance   = a_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !clear_busy_ff && (!a_valid_ff || advance);
   assign accept    = req_valid && req_ready;

   // The read happens at accept time; a store that retires on that same edge
   // is not yet visible in the read data, so it is picked up from the bypass.
   assign mem_word = fwd_hit_ff ? fwd_data_ff : ram_rd_data;

   // Memory write: the clearing pass owns the port until it is done.
   assign wr_en   = clear_busy_ff || (advance && lane_wr.en);
   assign wr_addr = clear_busy_ff ? clr_addr_ff : a_index;
   assign wr_data = clear_busy_ff ? '0 : lane_wr.data;

   lsbl_ram #(
      .DEPTH (MEM_WORDS),
      .WIDTH (32)
   ) u_ram (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr (req_index),
      .rd_data (ram_rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   lsbl_lane_unit u_lane (
      .req  (a_req_ff),
      .word (mem_word),
      .rsp  (lane_rsp),
      .wr   (lane_wr)
   );

   always_comb begin
      clear_busy_in = clear_busy_ff;
      clr_addr_in   = clr_addr_ff;
      if (clear_busy_ff) begin
         clr_addr_in = clr_addr_ff + mem_addr_type'(1);
         if (clr_addr_ff == mem_addr_type'(MEM_WORDS - 1)) begin
            clear_busy_in = 1'b0;
         end
      end

      a_valid_in  = a_valid_ff;
      a_req_in    = a_req_ff;
      fwd_hit_in  = fwd_hit_ff;
      fwd_data_in = fwd_data_ff;
      if (accept) begin
         a_valid_in  = 1'b1;
         a_req_in    = req_payload;
         fwd_hit_in  = wr_en && (wr_addr == req_index);
         fwd_data_in = wr_data;
      end else if (advance) begin
         a_valid_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
         rsp_in       = lane_rsp;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_busy_ff <= 1'b1;
         clr_addr_ff   <= '0;
         a_valid_ff    <= 1'b0;
         fwd_hit_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         clear_busy_ff <= clear_busy_in;
         clr_addr_ff   <= clr_addr_in;
         a_valid_ff    <= a_valid_in;
         fwd_hit_ff    <= fwd_hit_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      a_req_ff    <= a_req_in;
      fwd_data_ff <= fwd_data_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // Nothing is in flight while memory is being cleared.
   `ASSERT_RST(a_clear_idle, clock, reset, clear_busy_ff |-> (!a_valid_ff && !rsp_valid_ff), "request in flight during memory clear")
   // A stalled stage A keeps its request.
   `ASSERT_RST(a_stage_hold, clock, reset, (a_valid_ff && !advance) |=> (a_valid_ff && $stable(a_req_ff)), "stage A lost its request on a stall")
   // Memory is only written by the clearing pass or a retiring store.
   `ASSERT_RST(a_write_src, clock, reset, wr_en |-> (clear_busy_ff || (advance && lane_wr.en)), "unexpected memory write")

endmodule

`default_nettype wire

[rtl/core/lsbl_ram.sv]
`default_nettype none

module lsbl_ram #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read-before-write on a same-address collision
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[rtl/core/lsbl_lane_unit.sv]
`default_nettype none

module lsbl_lane_unit import lsbl_pkg::*; (
   input  wire req_type    req,
   input  wire logic [31:0] word,
   output      rsp_type    rsp,
   output      mem_wr_type wr
);

   logic [4:0]  shift;
   logic [31:0] byte_val;
   logic [31:0] half_val;
   logic [31:0] byte_merge;
   logic [31:0] half_merge;

   always_comb begin
      shift      = {req.byte_index, 3'b000};
      byte_val   = (word >> shift) & BYTE_MASK;
      half_val   = (word >> shift) & HALF_MASK;
      byte_merge = (word & ~(BYTE_MASK << shift)) | ((req.store_data & BYTE_MASK) << shift);
      half_merge = (word & ~(HALF_MASK << shift)) | ((req.store_data & HALF_MASK) << shift);

      rsp.write_value    = '0;
      rsp.write_reg      = '0;
      rsp.skip_writeback = 1'b0;
      rsp.kind_out       = req.instr_kind;
      rsp.opcode_out     = req.action;
      rsp.lane_error     = 1'b0;
      wr.en              = 1'b0;
      wr.data            = req.store_data;

      if (req.bubble) begin
         rsp.skip_writeback = 1'b1;
      end else if (req.instr_kind == KIND_I) begin
         rsp.write_reg = req.target_reg;
         case (req.action)
            OP_SB: begin
               wr.en              = 1'b1;
               wr.data            = byte_merge;
               rsp.skip_writeback = 1'b1;
            end
            OP_SH: begin
               if (req.byte_index == LANE_TOP) begin
                  rsp.lane_error = 1'b1;
               end else begin
                  wr.en   = 1'b1;
                  wr.data = half_merge;
               end
               rsp.skip_writeback = 1'b1;
            end
            OP_SW: begin
               wr.en              = 1'b1;
               rsp.skip_writeback = 1'b1;
            end
            OP_LB: begin
               rsp.write_value = byte_val[7] ? (byte_val | BYTE_SEXT) : byte_val;
            end
            OP_LW: begin
               rsp.write_value = word;
            end
            OP_LBU: begin
               rsp.write_value = byte_val;
            end
            OP_LHU: begin
               if (req.byte_index == LANE_TOP) begin
                  rsp.lane_error = 1'b1;
               end else begin
                  rsp.write_value = half_val;
               end
            end
            default: begin
               rsp.write_value = req.passed_value;
            end
         endcase
      end else if (req.instr_kind == KIND_R) begin
         rsp.write_value = req.passed_value;
         rsp.write_reg   = req.result_reg;
      end else begin
         // J-type and the unused format code
         rsp.write_reg = req.result_reg;
         if (req.action == OP_JAL) begin
            rsp.write_value = req.passed_value;
         end
      end
   end

endmodule

`default_nettype wire

[tb/tb.sv]
`default_nettype none

module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import lsbl_pkg::*;

   // Format codes the package does not name: J-type and the unused encoding.
   localparam logic [1:0] KIND_J    = 2'd2;
   localparam logic [1:0] KIND_SPARE = 2'd3;

   // ------------------------------------------------------------------
   // Clock and reset
   // ------------------------------------------------------------------
   logic clock = 1'b0;
   logic reset = 1'b1;

   always #4 clock = ~clock;

   // Synchronous reset, held high from time zero and asserted once only.
   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
   end

   // ------------------------------------------------------------------
   // DUT
   // ------------------------------------------------------------------
   logic    req_valid   = 1'b0;
   logic    req_ready;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_ready   = 1'b0;
   rsp_type rsp_payload;

   load_store_byte_lane_stage dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   // ------------------------------------------------------------------
   // Shared testbench state
   // ------------------------------------------------------------------
   req_type     instr_backlog[$];   // requests waiting to be offered
   rsp_type     wb_expected[$];     // predicted writeback results, oldest first
   logic [31:0] mem_image [MEM_WORDS];
   int          snd_idle_pct = 34;
   int          rcv_idle_pct = 69;
   logic        wb_hold      = 1'b0; // long receiver hold-off
   int          mismatch_cnt = 0;

   // ------------------------------------------------------------------
   // Predictor: memory stage behavior against a private copy of the
   // data memory. Stores update mem_image at the moment of acceptance,
   // so later loads see them in request order.
   // ------------------------------------------------------------------
   function automatic rsp_type mem_stage_result(input req_type rq);
      rsp_type      rs;
      mem_addr_type idx;
      int unsigned  sh;
      logic [31:0]  word;
      rs            = '0;
      rs.kind_out   = rq.instr_kind;
      rs.opcode_out = rq.action;
      idx  = mem_index(rq.word_address);
      sh   = 8 * rq.byte_index;
      word = mem_image[idx];
      if (rq.bubble) begin
         // bubble: nothing touched, only kind and opcode travel on
         rs.skip_writeback = 1'b1;
      end else if (rq.instr_kind == KIND_I) begin
         rs.write_reg = rq.target_reg;
         case (rq.action)
            OP_SB: begin
               mem_image[idx] = (word & ~(BYTE_MASK << sh)) |
                                ((rq.store_data & BYTE_MASK) << sh);
               rs.skip_writeback = 1'b1;
            end
            OP_SH: begin
               // halfword straddling lane three is refused, memory untouched
               if (rq.byte_index == LANE_TOP)
                  rs.lane_error = 1'b1;
               else
                  mem_image[idx] = (word & ~(HALF_MASK << sh)) |
                                   ((rq.store_data & HALF_MASK) << sh);
               rs.skip_writeback = 1'b1;
            end
            OP_SW: begin
               mem_image[idx]    = rq.store_data;
               rs.skip_writeback = 1'b1;
            end
            OP_LB: begin
               rs.write_value = (word >> sh) & BYTE_MASK;
               if (rs.write_value[7])
                  rs.write_value = rs.write_value | BYTE_SEXT;
            end
            OP_LW:  rs.write_value = word;
            OP_LBU: rs.write_value = (word >> sh) & BYTE_MASK;
            OP_LHU: begin
               if (rq.byte_index == LANE_TOP)
                  rs.lane_error = 1'b1;
               else
                  rs.write_value = (word >> sh) & HALF_MASK;
            end
            default: rs.write_value = rq.passed_value;
         endcase
      end else if (rq.instr_kind == KIND_R) begin
         // R-type forwards the ALU value regardless of opcode
         rs.write_value = rq.passed_value;
         rs.write_reg   = rq.result_reg;
      end else begin
         // J-type and the spare format: only JAL carries a link value
         rs.write_reg = rq.result_reg;
         if (rq.action == OP_JAL)
            rs.write_value = rq.passed_value;
      end
      return rs;
   endfunction

   // ------------------------------------------------------------------
   // Checking
   // ------------------------------------------------------------------
   task automatic report_mismatch(input string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      mismatch_cnt++;
   endtask

   task automatic compare_field(input string name, input logic [31:0] got,
                                input logic [31:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s got 0x%08h want 0x%08h", name, got, want));
   endtask

   task automatic check_writeback(input rsp_type got);
      rsp_type want;
      if (wb_expected.size() == 0) begin
         report_mismatch($sformatf("result with no request pending, value 0x%08h",
                                   got.write_value));
      end else begin
         want = wb_expected.pop_front();
         compare_field("write_value", got.write_value, want.write_value);
         compare_field("write_reg", 32'(got.write_reg), 32'(want.write_reg));
         compare_field("skip_writeback", 32'(got.skip_writeback),
                       32'(want.skip_writeback));
         compare_field("kind_out", 32'(got.kind_out), 32'(want.kind_out));
         compare_field("opcode_out", 32'(got.opcode_out), 32'(want.opcode_out));
         compare_field("lane_error", 32'(got.lane_error), 32'(want.lane_error));
      end
   endtask

   // ------------------------------------------------------------------
   // Driver: req_payload only changes when the slot is free, so valid and
   // payload are stable until the handshake. The accepted request is the
   // one sampled before this edge, which is what gets predicted.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready)
            wb_expected.push_back(mem_stage_result(req_payload));
         if (!req_valid || req_ready) begin
            if (instr_backlog.size() != 0 && $urandom_range(99) >= snd_idle_pct) begin
               req_payload <= instr_backlog.pop_front();
               req_valid   <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Monitor: checks each accepted result, then picks the next ready.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready)
            check_writeback(rsp_payload);
         rsp_ready <= !wb_hold && ($urandom_range(99) >= rcv_idle_pct);
      end
   end

   // ------------------------------------------------------------------
   // Stimulus helpers. The stimulus process works on the falling edge so
   // its blocking writes never race the clocked driver and monitor.
   // ------------------------------------------------------------------
   task automatic queue_instr(input logic [5:0] action, input logic [1:0] kind,
                              input logic bub, input logic [9:0] addr,
                              input logic [1:0] lane, input logic [31:0] sdata,
                              input logic [31:0] pval, input logic [4:0] rt,
                              input logic [4:0] rd);
      req_type rq;
      rq.action       = action;
      rq.instr_kind   = kind;
      rq.bubble       = bub;
      rq.word_address = addr;
      rq.byte_index   = lane;
      rq.store_data   = sdata;
      rq.passed_value = pval;
      rq.target_reg   = rt;
      rq.result_reg   = rd;
      instr_backlog.push_back(rq);
   endtask

   // Mostly loads and stores to a few hot words at both ends of memory, so
   // loads see earlier stores and back-to-back hits exercise the bypass.
   function automatic req_type random_request();
      req_type rq;
      int      pick;
      rq.action       = 6'($urandom);
      rq.instr_kind   = KIND_I;
      rq.bubble       = ($urandom_range(99) < 5);
      rq.byte_index   = 2'($urandom);
      rq.store_data   = $urandom;
      rq.passed_value = $urandom;
      rq.target_reg   = 5'($urandom);
      rq.result_reg   = 5'($urandom);
      pick = $urandom_range(99);
      if (pick < 60)
         rq.word_address = 10'($urandom_range(7));
      else if (pick < 85)
         rq.word_address = 10'($urandom_range(1023, 1016));
      else
         rq.word_address = 10'($urandom);
      pick = $urandom_range(99);
      if (pick < 70) begin
         case ($urandom_range(6))
            0: rq.action = OP_LB;
            1: rq.action = OP_LW;
            2: rq.action = OP_LBU;
            3: rq.action = OP_LHU;
            4: rq.action = OP_SB;
            5: rq.action = OP_SH;
            default: rq.action = OP_SW;
         endcase
      end else if (pick < 80) begin
         rq.instr_kind = KIND_R;
      end else if (pick < 90) begin
         rq.instr_kind = $urandom_range(1) ? KIND_J : KIND_SPARE;
         if ($urandom_range(1))
            rq.action = OP_JAL;
      end else if (pick < 95) begin
         // I-type with whatever opcode, mostly not a memory op
      end else begin
         rq.bubble     = 1'b1;
         rq.instr_kind = 2'($urandom);
      end
      return rq;
   endfunction

   // Sender pause: nothing new until every predicted result has come back.
   task automatic drain_all();
      while (instr_backlog.size() != 0 || req_valid || wb_expected.size() != 0)
         @(negedge clock);
   endtask

   task automatic run_phase(input int count, input int snd_pct, input int rcv_pct);
      snd_idle_pct = snd_pct;
      rcv_idle_pct = rcv_pct;
      repeat (count) instr_backlog.push_back(random_request());
      drain_all();
   endtask

   // ------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------
   initial begin
      foreach (mem_image[i]) mem_image[i] = '0;
      @(negedge clock);

      // Directed: field extremes, every opcode, lane-three halfword error,
      // sign versus zero extension, bypass after back-to-back stores,
      // bubbles hiding a store, and all four format codes.
      queue_instr(OP_SW,  KIND_I, 1'b0, 10'd0,    2'd0, 32'hffff_ffff, 32'h0, 5'd1,  5'd0);
      queue_instr(OP_LW,  KIND_I, 1'b0, 10'd0,    2'd0, 32'h0, 32'h0, 5'd2,  5'd0);
      queue_instr(OP_SB,  KIND_I, 1'b0, 10'd1023, 2'd3, 32'h1234_5680, 32'h0, 5'd3, 5'd0);
      queue_instr(OP_LB,  KIND_I, 1'b0, 10'd1023, 2'd3, 32'h0, 32'h0, 5'd31, 5'd0);
      queue_instr(OP_LBU, KIND_I, 1'b0, 10'd1023, 2'd3, 32'h0, 32'h0, 5'd4,  5'd0);
      queue_instr(OP_LB,  KIND_I, 1'b0, 10'd1023, 2'd0, 32'h0, 32'h0, 5'd5,  5'd0);
      queue_instr(OP_SH,  KIND_I, 1'b0, 10'd5,    2'd2, 32'h1234_abcd, 32'h0, 5'd6, 5'd0);
      queue_instr(OP_LHU, KIND_I, 1'b0, 10'd5,    2'd2, 32'h0, 32'h0, 5'd7,  5'd0);
      queue_instr(OP_SH,  KIND_I, 1'b0, 10'd5,    2'd3, 32'hffff_ffff, 32'h0, 5'd8, 5'd0);
      queue_instr(OP_LHU, KIND_I, 1'b0, 10'd5,    2'd3, 32'h0, 32'h0, 5'd9,  5'd0);
      queue_instr(OP_LW,  KIND_I, 1'b0, 10'd5,    2'd0, 32'h0, 32'h0, 5'd10, 5'd0);
      queue_instr(OP_SH,  KIND_I, 1'b0, 10'd6,    2'd1, 32'h0000_beef, 32'h0, 5'd11, 5'd0);
      queue_instr(OP_LHU, KIND_I, 1'b0, 10'd6,    2'd1, 32'h0, 32'h0, 5'd12, 5'd0);
      queue_instr(OP_SB,  KIND_I, 1'b0, 10'd7,    2'd0, 32'h0000_0011, 32'h0, 5'd13, 5'd0);
      queue_instr(OP_SB,  KIND_I, 1'b0, 10'd7,    2'd1, 32'h0000_0022, 32'h0, 5'd14, 5'd0);
      queue_instr(OP_SB,  KIND_I, 1'b0, 10'd7,    2'd2, 32'h0000_0033, 32'h0, 5'd15, 5'd0);
      queue_instr(OP_LW,  KIND_I, 1'b0, 10'd7,    2'd0, 32'h0, 32'h0, 5'd16, 5'd0);
      queue_instr(OP_SW,  KIND_I, 1'b1, 10'd7,    2'd0, 32'h0, 32'h0, 5'd17, 5'd18);
      queue_instr(OP_LW,  KIND_I, 1'b0, 10'd7,    2'd0, 32'h0, 32'h0, 5'd19, 5'd0);
      queue_instr(OP_SW,  KIND_R, 1'b0, 10'd7,    2'd0, 32'h0, 32'hdead_beef, 5'd0, 5'd31);
      queue_instr(OP_JAL, KIND_J, 1'b0, 10'd0,    2'd0, 32'h0, 32'h0000_0400, 5'd0, 5'd31);
      queue_instr(6'h3f,  KIND_J, 1'b0, 10'd0,    2'd0, 32'h0, 32'hffff_ffff, 5'd0, 5'd20);
      queue_instr(OP_JAL, KIND_SPARE, 1'b0, 10'd0, 2'd0, 32'h0, 32'h8000_0001, 5'd0, 5'd21);
      queue_instr(6'h00,  KIND_I, 1'b0, 10'd0,    2'd0, 32'h0, 32'hffff_ffff, 5'd31, 5'd0);
      queue_instr(OP_LHU, KIND_I, 1'b0, 10'd6,    2'd0, 32'h0, 32'h0, 5'd22, 5'd0);
      drain_all();

      // Backpressure: receiver holds off while the sender keeps offering,
      // so the stage fills and drops req_ready.
      repeat (60) instr_backlog.push_back(random_request());
      wb_hold = 1'b1;
      repeat (150) @(negedge clock);
      wb_hold = 1'b0;
      drain_all();

      run_phase(340, 34, 69);
      run_phase(340, 69, 34);
      run_phase(110, 0, 0);

      // catch any stray result after the last expected one
      repeat (12) @(negedge clock);
      if (mismatch_cnt == 0 && wb_expected.size() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

   // Watchdog: far beyond the slowest legal run, clearing pass included.
   initial begin
      #2ms;
      $display("status: fail");
      $finish;
   end

endmodule

`default_nettype wire
